// File: hdl/fau_pkg.sv
// fau_pkg: command and status codes plus the pipeline stage record
// shared by every module of the four-op signed alu; no dependencies
package fau_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_BADCMD  = 2'd2
  } status_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           cmd;
    status_t              status;
    logic [DataWidth-1:0] value;   // add, sub or mul result
    logic [DataWidth-1:0] rem;     // partial remainder
    logic [DataWidth-1:0] dq;      // dividend bits out at top, quotient bits in at bottom
    logic [DataWidth-1:0] mag_b;   // divisor magnitude
    logic                 neg_q;   // quotient sign
  } pipe_t;

endpackage

// File: hdl/four_op_signed_alu_unit.sv
// four_op_signed_alu_unit: top level, front stages, divider pipeline, output stage
// depends on fau_pkg, fau_front, fau_div_step, fau_back
//
// signed 32-bit alu: add, subtract, multiply (low 32 bits, wrapping) and
// divide (truncating toward zero). one item in carries command, operand_a and
// operand_b; one item out carries value and status (0 ok, 1 divide by zero,
// 2 invalid command, value zero on error). most negative over minus one wraps.
// both channels use valid/stall; an item moves when valid is high and stall low.
// 35 register stages: input register, operand stage, 32 divider stages (one
// quotient bit each) and the output register. every command goes through
// the same pipeline so order is kept. throughput is one item per cycle while
// the output is not stalled.
// the whole pipeline advances together; when the output holds an item and
// out_stall is high, every stage freezes and in_stall is raised, so nothing is
// lost or repeated. reset clears the valid bits only; the block holds no state.
module four_op_signed_alu_unit
  import fau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           command,
  input  logic [DataWidth-1:0] operand_a,
  input  logic [DataWidth-1:0] operand_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DataWidth-1:0] value,
  output logic [1:0]           status
);

  logic  en;
  pipe_t stage [DataWidth+1];

  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  fau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .q         (stage[0])
  );

  for (genvar i = 0; i < DataWidth; i++) begin : g_div
    fau_div_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (stage[i]),
      .q   (stage[i+1])
    );
  end

  fau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .d         (stage[DataWidth]),
    .out_valid (out_valid),
    .value     (value),
    .status    (status)
  );

endmodule

// File: hdl/fau_front.sv
// fau_front: input register and the operand stage (add, sub, mul, magnitudes)
// depends on fau_pkg
module fau_front
  import fau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0]           command,
  input  logic [DataWidth-1:0] operand_a,
  input  logic [DataWidth-1:0] operand_b,
  output pipe_t                q
);

  logic                 s1_valid;
  logic [2:0]           s1_cmd;
  logic [DataWidth-1:0] s1_a;
  logic [DataWidth-1:0] s1_b;
  pipe_t                q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd <= command;
      s1_a   <= operand_a;
      s1_b   <= operand_b;
    end
  end

  always_comb begin
    q_next        = '0;
    q_next.valid  = s1_valid;
    q_next.cmd    = s1_cmd;
    q_next.status = ST_OK;
    q_next.rem    = '0;
    q_next.dq     = s1_a[DataWidth-1] ? (~s1_a + 1'b1) : s1_a;
    q_next.mag_b  = s1_b[DataWidth-1] ? (~s1_b + 1'b1) : s1_b;
    q_next.neg_q  = s1_a[DataWidth-1] ^ s1_b[DataWidth-1];
    case (s1_cmd)
      CMD_ADD: q_next.value = s1_a + s1_b;
      CMD_SUB: q_next.value = s1_a - s1_b;
      CMD_MUL: q_next.value = s1_a * s1_b;
      CMD_DIV: begin
        q_next.value = '0;
        if (s1_b == '0) begin
          q_next.status = ST_DIVZERO;
        end
      end
      default: begin
        q_next.value  = '0;
        q_next.status = ST_BADCMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= q_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.cmd    <= q_next.cmd;
      q.status <= q_next.status;
      q.value  <= q_next.value;
      q.rem    <= q_next.rem;
      q.dq     <= q_next.dq;
      q.mag_b  <= q_next.mag_b;
      q.neg_q  <= q_next.neg_q;
    end
  end

endmodule

// File: hdl/fau_div_step.sv
// fau_div_step: one restoring division step, one quotient bit per stage
// depends on fau_pkg
module fau_div_step
  import fau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  pipe_t d,
  output pipe_t q
);

  logic [DataWidth:0] trial;
  logic [DataWidth:0] diff;
  logic               qbit;
  pipe_t              q_next;

  always_comb begin
    trial     = {d.rem, d.dq[DataWidth-1]};
    diff      = trial - {1'b0, d.mag_b};
    qbit      = ~diff[DataWidth];
    q_next    = d;
    q_next.rem = qbit ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    q_next.dq  = {d.dq[DataWidth-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= q_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.cmd    <= q_next.cmd;
      q.status <= q_next.status;
      q.value  <= q_next.value;
      q.rem    <= q_next.rem;
      q.dq     <= q_next.dq;
      q.mag_b  <= q_next.mag_b;
      q.neg_q  <= q_next.neg_q;
    end
  end

endmodule

// File: hdl/fau_back.sv
// fau_back: quotient sign fix, result select and the output register
// depends on fau_pkg
module fau_back
  import fau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  pipe_t                d,
  output logic                 out_valid,
  output logic [DataWidth-1:0] value,
  output logic [1:0]           status
);

  logic [DataWidth-1:0] value_next;

  always_comb begin
    if (d.status != ST_OK) begin
      value_next = '0;
    end else if (d.cmd == CMD_DIV) begin
      value_next = d.neg_q ? (~d.dq + 1'b1) : d.dq;
    end else begin
      value_next = d.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value  <= value_next;
      status <= d.status;
    end
  end

endmodule

// File: hdl/fau_checker.sv
// fau_checker: port-level assertions for the four-op signed alu
// depends on fau_pkg; bound to four_op_signed_alu_unit
module fau_checker
  import fau_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DataWidth-1:0] value,
  input logic [1:0]           status
);

  // error items carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == '0)
    else $error("error item with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_DIVZERO || status == ST_BADCMD)
    else $error("bad status code");

  // input backpressure only comes from a stalled output item
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("stalled output item changed");

endmodule

bind four_op_signed_alu_unit fau_checker u_fau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .status    (status)
);
